@@ design/yrg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// yrg_pkg
// shared types and constants for the red/green hue ratio block
// ----------------------------------------------------------------------------
package yrg_pkg;

  // pixel layouts of the format register; code 3 is unused
  typedef enum logic [1:0] {
    FmtYuyv   = 2'd0,
    FmtY1vy0u = 2'd1,
    Fmt444    = 2'd2
  } pix_fmt_e;

  localparam int unsigned FracBits = 15;
  localparam int unsigned SumW     = 26;   // signed q15 sums of one colour
  localparam int unsigned HueW     = 8;

  localparam logic [7:0] ChromaMid = 8'd128;
  localparam logic signed [17:0] CoefRCr = 18'sd45941;
  localparam logic signed [17:0] CoefGCb = -18'sd11277;
  localparam logic signed [17:0] CoefGCr = -18'sd23401;
  localparam logic [SumW-1:0] RoundHalf = SumW'(1 << (FracBits - 1));
  localparam logic [HueW-1:0] HueSat = 8'd255;

  // divider: quotient bits resolved in each pipeline stage
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = HueW / DivBitsPerStage;

  // sideband that travels with each pixel beat
  typedef struct packed {
    logic last;   // final hue of the input group
    logic sat;    // red not above green, hue forced to 255
  } beat_tag_t;

endpackage : yrg_pkg
`default_nettype wire

@@ design/yuv_red_green_hue_ratio.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_red_green_hue_ratio
// green over red ratio of bt.601 fixed point colour, from packed yuv groups
// ----------------------------------------------------------------------------
// One beat on start_i carries a four-byte pixel group; it is taken at a rising
// edge where start_i is high and busy_o low. Each luma sample of the group
// gives one hue on hue_o, shown for exactly one cycle with valid_o high, and
// last_of_item_o marks the final hue of the group. Results cannot be held off:
// the receiver must take every one. A 4:4:4 group gives one hue and the block
// takes a new group every cycle. A YUYV or Y1VY0U group gives two hues, one
// per cycle through the single pixel lane, so busy_o rises for the cycle
// after such a group is taken and no new group is taken in that cycle.
// Groups taken while the format register holds the unused code are dropped
// without results. From the taking edge the first hue passes the input,
// multiply, sum and clamp registers, four divider stages and the output
// register. Write cfg_we_i only while no group is in flight.
// ----------------------------------------------------------------------------
module yuv_red_green_hue_ratio
  import yrg_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire logic [7:0]      byte_0_i,
  input  wire logic [7:0]      byte_1_i,
  input  wire logic [7:0]      byte_2_i,
  input  wire logic [7:0]      byte_3_i,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_data_i,
  output logic                 valid_o,
  output logic [HueW-1:0]      hue_o,
  output logic                 last_of_item_o
);

  // format register
  logic [1:0] fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtYuyv;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // splitter: first pixel goes straight in, second of a pair is held and follows in the next cycle
  // ---------------------------------------------------------------------------
  logic       accept;
  logic       pend_q, pend_d;
  logic [7:0] pend_y_q, pend_cb_q, pend_cr_q;
  logic [7:0] a_y, a_cb, a_cr, b_y;
  logic       a_ok, a_last, is_pair;

  assign accept = start_i && !busy_o;
  assign busy_o = pend_q;

  always_comb begin
    a_y     = byte_0_i;
    a_cb    = byte_1_i;
    a_cr    = byte_3_i;
    b_y     = byte_2_i;
    a_ok    = 1'b1;
    a_last  = 1'b0;
    is_pair = 1'b0;
    unique case (fmt_q)
      FmtYuyv: begin
        is_pair = 1'b1;
      end
      FmtY1vy0u: begin
        a_y     = byte_2_i;
        a_cb    = byte_3_i;
        a_cr    = byte_1_i;
        b_y     = byte_0_i;
        is_pair = 1'b1;
      end
      Fmt444: begin
        a_cr   = byte_2_i;
        a_last = 1'b1;
      end
      default: begin
        // unused code: group is dropped
        a_ok = 1'b0;
      end
    endcase
  end

  assign pend_d = accept && is_pair;

  // ---------------------------------------------------------------------------
  // stage 1: pixel register
  // ---------------------------------------------------------------------------
  logic       s1_valid_q, s1_last_q;
  logic [7:0] s1_y_q, s1_cb_q, s1_cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      pend_q     <= pend_d;
      s1_valid_q <= pend_q || (accept && a_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_d) begin
      pend_y_q  <= b_y;
      pend_cb_q <= a_cb;
      pend_cr_q <= a_cr;
    end
    if (pend_q) begin
      s1_y_q    <= pend_y_q;
      s1_cb_q   <= pend_cb_q;
      s1_cr_q   <= pend_cr_q;
      s1_last_q <= 1'b1;
    end else begin
      s1_y_q    <= a_y;
      s1_cb_q   <= a_cb;
      s1_cr_q   <= a_cr;
      s1_last_q <= a_last;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: chroma products
  // ---------------------------------------------------------------------------
  logic signed [7:0] dcb, dcr;
  logic            s2_valid_q, s2_last_q;
  logic [7:0]      s2_y_q;
  logic [SumW-1:0] s2_pr_q, s2_pgb_q, s2_pgr_q;

  // offset chroma, -128..127
  assign dcb = signed'(8'(s1_cb_q - ChromaMid));
  assign dcr = signed'(8'(s1_cr_q - ChromaMid));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_last_q <= s1_last_q;
    s2_y_q    <= s1_y_q;
    s2_pr_q   <= SumW'(SumW'(dcr) * SumW'(CoefRCr));
    s2_pgb_q  <= SumW'(SumW'(dcb) * SumW'(CoefGCb));
    s2_pgr_q  <= SumW'(SumW'(dcr) * SumW'(CoefGCr));
  end

  // ---------------------------------------------------------------------------
  // stage 3: sums, round to nearest, clamp to a byte
  // ---------------------------------------------------------------------------
  // arithmetic shift floors; negative goes to 0, above 255 to 255
  function automatic logic [7:0] round_clamp(input logic [SumW-1:0] sum);
    logic [SumW-FracBits-1:0] v;
    v = sum[SumW-1:FracBits];
    if (v[SumW-FracBits-1]) begin
      return 8'd0;
    end else if (v[SumW-FracBits-2:8] != '0) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  logic [SumW-1:0] base, sum_r, sum_g;
  logic            s3_valid_q, s3_last_q;
  logic [7:0]      s3_r_q, s3_g_q;

  assign base  = SumW'({s2_y_q, {FracBits{1'b0}}});
  assign sum_r = base + s2_pr_q + RoundHalf;
  assign sum_g = base + s2_pgb_q + s2_pgr_q + RoundHalf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_last_q <= s2_last_q;
    s3_r_q    <= round_clamp(sum_r);
    s3_g_q    <= round_clamp(sum_g);
  end

  // ---------------------------------------------------------------------------
  // stages 4 to 7: ratio g*256/r in the divider pipe
  // ---------------------------------------------------------------------------
  beat_tag_t       div_tag_in, div_tag_out;
  logic            div_valid;
  logic [HueW-1:0] div_quo;

  assign div_tag_in.last = s3_last_q;
  assign div_tag_in.sat  = (s3_r_q <= s3_g_q);

  yrg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid_q),
    .tag_i   (div_tag_in),
    .num_i   (s3_g_q),
    .den_i   (s3_r_q),
    .valid_o (div_valid),
    .tag_o   (div_tag_out),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------------------
  // output register: one hue beat per cycle
  // ---------------------------------------------------------------------------
  logic            out_valid_q, out_last_q;
  logic [HueW-1:0] out_hue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_last_q <= div_tag_out.last;
    out_hue_q  <= div_tag_out.sat ? HueSat : div_quo;
  end

  assign valid_o        = out_valid_q;
  assign hue_o          = out_hue_q;
  assign last_of_item_o = out_last_q;

endmodule : yuv_red_green_hue_ratio
`default_nettype wire

@@ design/yrg_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// yrg_div
// pipelined restoring divider, floor(num*256/den) for num below den
// ----------------------------------------------------------------------------
module yrg_div
  import yrg_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire beat_tag_t       tag_i,
  input  wire logic [HueW-1:0] num_i,
  input  wire logic [HueW-1:0] den_i,
  output logic                 valid_o,
  output beat_tag_t            tag_o,
  output logic [HueW-1:0]      quo_o
);

  logic            valid_q [DivStages];
  beat_tag_t       tag_q   [DivStages];
  logic [HueW-1:0] rem_q   [DivStages];
  logic [HueW-1:0] den_q   [DivStages];
  logic [HueW-1:0] quo_q   [DivStages];

  // DivBitsPerStage shift-subtract steps; remainder stays below den when num < den
  function automatic logic [HueW+DivBitsPerStage-1:0] div_steps(
    input logic [HueW-1:0] rem,
    input logic [HueW-1:0] den
  );
    logic [HueW:0]            t;
    logic [HueW-1:0]          r;
    logic [DivBitsPerStage-1:0] q;
    r = rem;
    q = '0;
    for (int i = 0; i < DivBitsPerStage; i++) begin
      t = {r, 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        q[DivBitsPerStage-1-i] = 1'b1;
      end
      r = t[HueW-1:0];
    end
    return {r, q};
  endfunction

  logic [HueW+DivBitsPerStage-1:0] step_res [DivStages];

  always_comb begin
    step_res[0] = div_steps(num_i, den_i);
    for (int s = 1; s < DivStages; s++) begin
      step_res[s] = div_steps(rem_q[s-1], den_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DivStages; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < DivStages; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    den_q[0] <= den_i;
    rem_q[0] <= step_res[0][HueW+DivBitsPerStage-1:DivBitsPerStage];
    quo_q[0] <= HueW'(step_res[0][DivBitsPerStage-1:0]);
    for (int s = 1; s < DivStages; s++) begin
      tag_q[s] <= tag_q[s-1];
      den_q[s] <= den_q[s-1];
      rem_q[s] <= step_res[s][HueW+DivBitsPerStage-1:DivBitsPerStage];
      quo_q[s] <= {quo_q[s-1][HueW-DivBitsPerStage-1:0],
                   step_res[s][DivBitsPerStage-1:0]};
    end
  end

  assign valid_o = valid_q[DivStages-1];
  assign tag_o   = tag_q[DivStages-1];
  assign quo_o   = quo_q[DivStages-1];

endmodule : yrg_div
`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the red/green hue ratio block
// ----------------------------------------------------------------------------
// Pixel groups go in on the start/busy handshake. The bench holds its own
// model of the bt.601 q15 colour maths and of the pixel format register. Every
// hue beat is checked against the oldest expected beat in a scoreboard. A
// directed set covers the byte extremes and every format, the unused format
// code among them. Random phases then sweep all formats under three sender
// idle profiles, with the format register rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top
  import yrg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // format code with no layout behind it: groups give no hue
  localparam logic [1:0] FmtUnused = 2'd3;

  // cycles to let pass after the last expected hue, covering the pipe depth
  localparam int unsigned SettleCycles = 12;

  // ----------------------------------------------------------------------------
  // scoreboard: predicts the hue beats of each group and checks the dut output
  // ----------------------------------------------------------------------------
  class hue_scoreboard;
    logic [HueW-1:0] hue_q[$];
    logic            last_q[$];
    logic [1:0]      fmt;
    int unsigned     errors;
    int unsigned     checked;

    function new();
      fmt     = FmtYuyv;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_format(logic [1:0] f);
      fmt = f;
    endfunction

    function int unsigned pending();
      return hue_q.size();
    endfunction

    // round to nearest (floor of q + half), then clamp to a byte
    function automatic int clamp_q15(int q);
      int v;
      v = (q + (1 <<< 14)) >>> 15;
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    function automatic logic [HueW-1:0] ratio_of(logic [7:0] y, logic [7:0] cb,
                                                 logic [7:0] cr);
      int dcb;
      int dcr;
      int luma_q;
      int red;
      int green;
      int quot;
      dcb    = int'(cb) - 128;
      dcr    = int'(cr) - 128;
      luma_q = int'(y) * 32768;
      red    = clamp_q15(luma_q + 45941 * dcr);
      green  = clamp_q15(luma_q - 11277 * dcb - 23401 * dcr);
      if (red <= green) return HueSat;
      quot = (green * 256) / red;
      return quot[HueW-1:0];
    endfunction

    function void push_beat(logic [HueW-1:0] h, logic l);
      hue_q.push_back(h);
      last_q.push_back(l);
    endfunction

    function void note_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                             logic [7:0] b3);
      case (fmt)
        FmtYuyv: begin
          push_beat(ratio_of(b0, b1, b3), 1'b0);
          push_beat(ratio_of(b2, b1, b3), 1'b1);
        end
        FmtY1vy0u: begin
          push_beat(ratio_of(b2, b3, b1), 1'b0);
          push_beat(ratio_of(b0, b3, b1), 1'b1);
        end
        Fmt444: begin
          push_beat(ratio_of(b0, b1, b2), 1'b1);
        end
        default: begin
          // unused code: the group is dropped
        end
      endcase
    endfunction

    function void check_beat(logic [HueW-1:0] h, logic l);
      logic [HueW-1:0] exp_hue;
      logic            exp_last;
      if (hue_q.size() == 0) begin
        $error("hue beat with nothing expected: hue %0d last %0d", h, l);
        errors++;
        return;
      end
      exp_hue  = hue_q.pop_front();
      exp_last = last_q.pop_front();
      checked++;
      if (h !== exp_hue) begin
        $error("field hue: expected %0d, got %0d", exp_hue, h);
        errors++;
      end
      if (l !== exp_last) begin
        $error("field last_of_item: expected %0d, got %0d", exp_last, l);
        errors++;
      end
    endfunction
  endclass

  // ----------------------------------------------------------------------------
  // clock, reset and dut
  // ----------------------------------------------------------------------------
  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  logic [7:0]      byte_0_i;
  logic [7:0]      byte_1_i;
  logic [7:0]      byte_2_i;
  logic [7:0]      byte_3_i;
  logic            cfg_we_i;
  logic [1:0]      cfg_data_i;
  logic            valid_o;
  logic [HueW-1:0] hue_o;
  logic            last_of_item_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  yuv_red_green_hue_ratio dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .byte_0_i       (byte_0_i),
    .byte_1_i       (byte_1_i),
    .byte_2_i       (byte_2_i),
    .byte_3_i       (byte_3_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .valid_o        (valid_o),
    .hue_o          (hue_o),
    .last_of_item_o (last_of_item_o)
  );

  hue_scoreboard sb;
  int unsigned   groups_in;

  // every hue beat lasts one cycle and is taken at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_beat(hue_o, last_of_item_o);
    end
  end

  // ----------------------------------------------------------------------------
  // drive tasks: all input changes happen on the falling edge
  // ----------------------------------------------------------------------------

  // offer one group and hold it until an edge sees busy low
  task automatic send_group(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
    start_i  <= 1'b1;
    byte_0_i <= b0;
    byte_1_i <= b1;
    byte_2_i <= b2;
    byte_3_i <= b3;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_group(b0, b1, b2, b3);
    groups_in++;
    @(negedge clk_i);
  endtask

  // sender gap: each cycle idles with the given chance, bytes carry junk
  task automatic idle_gap(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start_i  <= 1'b0;
      byte_0_i <= 8'($urandom);
      byte_1_i <= 8'($urandom);
      byte_2_i <= 8'($urandom);
      byte_3_i <= 8'($urandom);
      @(negedge clk_i);
    end
  endtask

  // stop sending until every expected hue has come out
  task automatic wait_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // format writes only with the pipe empty; dropped groups leave no trace in
  // the scoreboard, so the pipe depth is waited out as well
  task automatic write_format(input logic [1:0] f);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= f;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_format(f);
  endtask

  // random group: mostly uniform bytes, sometimes chroma close to mid grey so
  // that red and green land near each other
  task automatic send_random(input logic [1:0] f);
    logic [7:0] b[4];
    for (int i = 0; i < 4; i++) b[i] = 8'($urandom);
    if ($urandom_range(9) < 3) begin
      b[1] = 8'(120 + $urandom_range(16));
      if (f == Fmt444) b[2] = 8'(120 + $urandom_range(16));
      else             b[3] = 8'(120 + $urandom_range(16));
    end
    send_group(b[0], b[1], b[2], b[3]);
  endtask

  // ----------------------------------------------------------------------------
  // stimulus
  // ----------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0] fmt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } dir_group_t;

  // directed set: byte extremes, grey (red equals green), saturated colours
  localparam int unsigned NumDirected = 19;
  localparam dir_group_t DirSet[NumDirected] = '{
    '{FmtYuyv,   8'h00, 8'h00, 8'h00, 8'h00},
    '{FmtYuyv,   8'hff, 8'hff, 8'hff, 8'hff},
    '{FmtYuyv,   8'hff, 8'h00, 8'h00, 8'hff},
    '{FmtYuyv,   8'h80, 8'h80, 8'h80, 8'h80},
    '{FmtYuyv,   8'h00, 8'hff, 8'hff, 8'h00},
    '{FmtYuyv,   8'h40, 8'h00, 8'hc0, 8'hff},
    '{FmtY1vy0u, 8'hff, 8'hff, 8'h00, 8'h00},
    '{FmtY1vy0u, 8'h00, 8'h00, 8'hff, 8'hff},
    '{FmtY1vy0u, 8'h80, 8'hc0, 8'h80, 8'h40},
    '{FmtY1vy0u, 8'h10, 8'hff, 8'hf0, 8'h00},
    '{FmtY1vy0u, 8'h80, 8'h80, 8'h80, 8'h80},
    '{Fmt444,    8'h00, 8'h80, 8'hff, 8'haa},
    '{Fmt444,    8'hff, 8'h00, 8'hff, 8'h55},
    '{Fmt444,    8'h80, 8'h80, 8'h80, 8'hff},
    '{Fmt444,    8'h40, 8'h40, 8'hc0, 8'h00},
    '{Fmt444,    8'hff, 8'hff, 8'h00, 8'hff},
    '{Fmt444,    8'h00, 8'h00, 8'h00, 8'h00},
    '{FmtUnused, 8'h12, 8'h34, 8'h56, 8'h78},
    '{FmtUnused, 8'hff, 8'hff, 8'hff, 8'hff}
  };

  localparam int unsigned IdlePct[3] = '{11, 51, 0};

  initial begin
    logic [1:0] fmts[4];
    int unsigned n_items;
    sb         = new();
    groups_in  = 0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    byte_0_i   = 8'h00;
    byte_1_i   = 8'h00;
    byte_2_i   = 8'h00;
    byte_3_i   = 8'h00;
    cfg_we_i   = 1'b0;
    cfg_data_i = FmtYuyv;
    fmts       = '{FmtYuyv, FmtY1vy0u, Fmt444, FmtUnused};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, back to back within one format
    for (int i = 0; i < NumDirected; i++) begin
      if (i == 0 || DirSet[i].fmt != DirSet[i-1].fmt) write_format(DirSet[i].fmt);
      send_group(DirSet[i].b0, DirSet[i].b1, DirSet[i].b2, DirSet[i].b3);
    end

    // random phases: every format under each idle profile
    for (int m = 0; m < 3; m++) begin
      for (int k = 0; k < 4; k++) begin
        write_format(fmts[k]);
        n_items = (fmts[k] == FmtUnused) ? 20 : 100;
        for (int j = 0; j < n_items; j++) begin
          idle_gap(IdlePct[m]);
          // now and then hold off until the pipe has emptied
          if ($urandom_range(99) == 0) wait_drained();
          send_random(fmts[k]);
        end
      end
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);

    $display("tb_top: %0d groups sent, %0d hue beats checked, %0d errors",
             groups_in, sb.checked, sb.errors);
    $display("tb_top: all four format codes under three sender idle profiles");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      if (sb.pending() != 0) $error("%0d hue beats never arrived", sb.pending());
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
design/yrg_pkg.sv
design/yrg_div.sv
design/yuv_red_green_hue_ratio.sv
bench/tb_top.sv
